/* rtl/smcj_pkg.sv */
package smcj_pkg;

  localparam int LIST_DEPTH = 1024;
  localparam int VALUE_BITS = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_W      = 7;
  localparam int OUT_DATA_W = 88;

  localparam logic [KEY_W-1:0] KEY_BITS_RESET = KEY_W'(16);

  // input item kinds
  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_PULL   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_SORT_BEGIN,
    OP_NEXT_LIST,
    OP_RD_I,
    OP_CAP_KI,
    OP_SCAN,
    OP_WR_ORD,
    OP_JOIN_INIT,
    OP_FETCH_ORD,
    OP_FETCH_VAL,
    OP_CAPTURE,
    OP_SEEK_STEP,
    OP_SET_RUN,
    OP_STAGE,
    OP_ADV_STEP,
    OP_TAKE_B,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic nxt;   // fetch at cursor + 1 instead of cursor
  } cmd_t;

  typedef struct packed {
    logic sorted;
    logic sel_b;
    logic i_lt_n;
    logic scan_done;
    logic have;
    logic keys_eq;
    logic adv_b_ok;
    logic adv_a_ok;
    logic out_free;
  } stat_t;

endpackage

/* rtl/smcj_ram.sv */
module smcj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/smcj_datapath.sv */
module smcj_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  smcj_pkg::cmd_t                cmd,
  output smcj_pkg::stat_t               stat,
  input  logic                          cfg_wen,
  input  logic [smcj_pkg::KEY_W-1:0]    cfg_wdata,
  input  logic [1:0]                    action,
  input  logic [smcj_pkg::VALUE_BITS-1:0] value,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [smcj_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);

  localparam int VW = smcj_pkg::VALUE_BITS;
  localparam int IW = smcj_pkg::IDX_W;
  localparam int CW = smcj_pkg::CNT_W;
  localparam logic [CW-1:0] FULL = CW'(smcj_pkg::LIST_DEPTH);

  logic [smcj_pkg::KEY_W-1:0] key_bits;
  logic [CW-1:0] count_a, count_b, ca, cb, rb, si, sj, sjd;
  logic          sel, sv, ovf, sorted;
  logic [IW-1:0] rank;
  logic [VW-1:0] ki;
  logic [IW-1:0] pa_t, pb_t, pa, pb;
  logic [VW-1:0] va_t, vb_t, va, vb;
  logic          stage_vr;
  logic [IW-1:0] stage_pa, stage_pb;
  logic [VW-1:0] stage_mv;
  logic          out_vr, out_last, out_ovf;
  logic [IW-1:0] out_pa, out_pb;
  logic [VW-1:0] out_mv;

  logic [IW-1:0] oa_q, ob_q, sort_addr, sa_raddr, sb_raddr, oa_raddr, ob_raddr;
  logic [VW-1:0] sa_q, sb_q, sq, kq, key_mask, ka_t, kb_t, kcur, mv;
  logic [CW-1:0] n_sel, ca_inc, cb_inc;
  logic          sa_we, sb_we, oa_we, ob_we, have, rank_hit;

  // key mask and shifted merge value; 64 or more key bits shift everything away
  assign key_mask = (key_bits >= smcj_pkg::KEY_W'(VW)) ? '1 :
                    ((VW'(1) << key_bits[$clog2(VW)-1:0]) - VW'(1));
  assign mv       = (key_bits >= smcj_pkg::KEY_W'(VW)) ? '0 :
                    ((va ^ vb) >> key_bits[$clog2(VW)-1:0]);

  assign ca_inc = ca + CW'(1);
  assign cb_inc = cb + CW'(1);
  assign n_sel  = sel ? count_b : count_a;
  assign sq     = sel ? sb_q : sa_q;
  assign kq     = sq & key_mask;
  assign ka_t   = va_t & key_mask;
  assign kb_t   = vb_t & key_mask;
  assign kcur   = vb & key_mask;
  assign have   = (ca < count_a) && (cb < count_b);
  assign rank_hit = sv && ((kq < ki) || ((kq == ki) && (sjd < si)));

  // memory addressing
  assign sort_addr = (cmd.op == smcj_pkg::OP_SCAN) ? sj[IW-1:0] : si[IW-1:0];
  assign sa_raddr  = (cmd.op == smcj_pkg::OP_FETCH_VAL) ? oa_q : sort_addr;
  assign sb_raddr  = (cmd.op == smcj_pkg::OP_FETCH_VAL) ? ob_q : sort_addr;
  assign oa_raddr  = cmd.nxt ? ca_inc[IW-1:0] : ca[IW-1:0];
  assign ob_raddr  = cmd.nxt ? cb_inc[IW-1:0] : cb[IW-1:0];
  assign sa_we = (cmd.op == smcj_pkg::OP_LOAD) && (action == smcj_pkg::ACT_LOAD_A) &&
                 (count_a < FULL);
  assign sb_we = (cmd.op == smcj_pkg::OP_LOAD) && (action == smcj_pkg::ACT_LOAD_B) &&
                 (count_b < FULL);
  assign oa_we = (cmd.op == smcj_pkg::OP_WR_ORD) && !sel;
  assign ob_we = (cmd.op == smcj_pkg::OP_WR_ORD) && sel;

  smcj_ram #(.WIDTH(VW), .DEPTH(smcj_pkg::LIST_DEPTH)) u_store_a (
    .clk(clk), .we(sa_we), .waddr(count_a[IW-1:0]), .wdata(value),
    .raddr(sa_raddr), .rdata(sa_q)
  );
  smcj_ram #(.WIDTH(VW), .DEPTH(smcj_pkg::LIST_DEPTH)) u_store_b (
    .clk(clk), .we(sb_we), .waddr(count_b[IW-1:0]), .wdata(value),
    .raddr(sb_raddr), .rdata(sb_q)
  );
  smcj_ram #(.WIDTH(IW), .DEPTH(smcj_pkg::LIST_DEPTH)) u_order_a (
    .clk(clk), .we(oa_we), .waddr(rank), .wdata(si[IW-1:0]),
    .raddr(oa_raddr), .rdata(oa_q)
  );
  smcj_ram #(.WIDTH(IW), .DEPTH(smcj_pkg::LIST_DEPTH)) u_order_b (
    .clk(clk), .we(ob_we), .waddr(rank), .wdata(si[IW-1:0]),
    .raddr(ob_raddr), .rdata(ob_q)
  );

  // status to controller
  always_comb begin
    stat.sorted    = sorted;
    stat.sel_b     = sel;
    stat.i_lt_n    = si < n_sel;
    stat.scan_done = (sj == n_sel) && !sv;
    stat.have      = have;
    stat.keys_eq   = ka_t == kb_t;
    stat.adv_b_ok  = (cb_inc < count_b) && (kb_t == kcur);
    stat.adv_a_ok  = (ca_inc < count_a) && (ka_t == kcur);
    stat.out_free  = !m_tvalid || m_tready;
  end

  // control state: counts, cursors, flags, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      key_bits <= smcj_pkg::KEY_BITS_RESET;
      count_a  <= '0;
      count_b  <= '0;
      ca       <= '0;
      cb       <= '0;
      rb       <= '0;
      ovf      <= 1'b0;
      sorted   <= 1'b0;
      sv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wen) begin
        key_bits <= cfg_wdata;
        sorted   <= 1'b0;
      end
      unique case (cmd.op)
        smcj_pkg::OP_LOAD: begin
          sorted <= 1'b0;
          if (action == smcj_pkg::ACT_LOAD_A) begin
            if (count_a < FULL) count_a <= count_a + CW'(1);
            else ovf <= 1'b1;
          end else begin
            if (count_b < FULL) count_b <= count_b + CW'(1);
            else ovf <= 1'b1;
          end
        end
        smcj_pkg::OP_CLEAR: begin
          count_a <= '0;
          count_b <= '0;
          ca      <= '0;
          cb      <= '0;
          rb      <= '0;
          ovf     <= 1'b0;
          sorted  <= 1'b0;
        end
        smcj_pkg::OP_CAP_KI: sv <= 1'b0;
        smcj_pkg::OP_SCAN:   sv <= sj < n_sel;
        smcj_pkg::OP_JOIN_INIT: begin
          ca     <= '0;
          cb     <= '0;
          sorted <= 1'b1;
        end
        smcj_pkg::OP_SEEK_STEP: begin
          if (ka_t < kb_t) ca <= ca_inc;
          else if (kb_t < ka_t) cb <= cb_inc;
          else rb <= cb;
        end
        smcj_pkg::OP_SET_RUN: rb <= cb;
        smcj_pkg::OP_ADV_STEP: begin
          if (stat.adv_b_ok) begin
            cb <= cb_inc;
          end else if (stat.adv_a_ok) begin
            ca <= ca_inc;
            cb <= rb;
          end else begin
            ca <= ca_inc;
            cb <= cb_inc;
          end
        end
        smcj_pkg::OP_EMIT: m_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      smcj_pkg::OP_SORT_BEGIN: begin
        sel <= 1'b0;
        si  <= '0;
      end
      smcj_pkg::OP_NEXT_LIST: begin
        sel <= 1'b1;
        si  <= '0;
      end
      smcj_pkg::OP_CAP_KI: begin
        ki   <= kq;
        sj   <= '0;
        rank <= '0;
      end
      smcj_pkg::OP_SCAN: begin
        if (sj < n_sel) sj <= sj + CW'(1);
        sjd <= sj;
        if (rank_hit) rank <= rank + IW'(1);
      end
      smcj_pkg::OP_WR_ORD: si <= si + CW'(1);
      smcj_pkg::OP_FETCH_VAL: begin
        pa_t <= oa_q;
        pb_t <= ob_q;
      end
      smcj_pkg::OP_CAPTURE: begin
        va_t <= sa_q;
        vb_t <= sb_q;
      end
      smcj_pkg::OP_SEEK_STEP: begin
        if (ka_t == kb_t) begin
          pa <= pa_t;
          va <= va_t;
          pb <= pb_t;
          vb <= vb_t;
        end
      end
      smcj_pkg::OP_ADV_STEP: begin
        if (stat.adv_b_ok) begin
          pb <= pb_t;
          vb <= vb_t;
        end else if (stat.adv_a_ok) begin
          pa <= pa_t;
          va <= va_t;
        end
      end
      smcj_pkg::OP_TAKE_B: begin
        pb <= pb_t;
        vb <= vb_t;
      end
      smcj_pkg::OP_STAGE: begin
        stage_vr <= have;
        stage_pa <= have ? pa : '0;
        stage_pb <= have ? pb : '0;
        stage_mv <= have ? mv : '0;
      end
      smcj_pkg::OP_EMIT: begin
        out_vr   <= stage_vr;
        out_last <= stage_vr && !have;
        out_pa   <= stage_pa;
        out_pb   <= stage_pb;
        out_mv   <= stage_mv;
        out_ovf  <= ovf;
      end
      default: ;
    endcase
  end

  assign m_tuser = out_vr;
  assign m_tlast = out_last;
  assign m_tdata = {3'b000, out_ovf, out_mv, out_pb, out_pa};

endmodule

/* rtl/smcj_ctrl.sv */
module smcj_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [1:0]      action,
  input  smcj_pkg::stat_t stat,
  output smcj_pkg::cmd_t  cmd
);

  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_SRT_TOP  = 19'h00002,
    ST_SRT_KI   = 19'h00004,
    ST_SRT_SCAN = 19'h00008,
    ST_SRT_WR   = 19'h00010,
    ST_SEEK_TOP = 19'h00020,
    ST_SEEK_F2  = 19'h00040,
    ST_SEEK_F3  = 19'h00080,
    ST_SEEK_CMP = 19'h00100,
    ST_PULL_CHK = 19'h00200,
    ST_ADV_F1   = 19'h00400,
    ST_ADV_F2   = 19'h00800,
    ST_ADV_F3   = 19'h01000,
    ST_ADV_DEC  = 19'h02000,
    ST_RB_F1    = 19'h04000,
    ST_RB_F2    = 19'h08000,
    ST_RB_F3    = 19'h10000,
    ST_RB_SET   = 19'h20000,
    ST_EMIT     = 19'h40000
  } state_t;

  state_t state, state_next;
  logic   in_adv, in_adv_next;

  assign s_tready = state == ST_IDLE;

  // sequencing of load, sort, seek and advance
  always_comb begin
    state_next  = state;
    in_adv_next = in_adv;
    cmd.op      = smcj_pkg::OP_NONE;
    cmd.nxt     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (action)
            smcj_pkg::ACT_LOAD_A, smcj_pkg::ACT_LOAD_B: cmd.op = smcj_pkg::OP_LOAD;
            smcj_pkg::ACT_CLEAR: cmd.op = smcj_pkg::OP_CLEAR;
            default: begin
              if (stat.sorted) begin
                state_next = ST_PULL_CHK;
              end else begin
                cmd.op     = smcj_pkg::OP_SORT_BEGIN;
                state_next = ST_SRT_TOP;
              end
            end
          endcase
        end
      end
      ST_SRT_TOP: begin
        if (stat.i_lt_n) begin
          cmd.op     = smcj_pkg::OP_RD_I;
          state_next = ST_SRT_KI;
        end else if (!stat.sel_b) begin
          cmd.op = smcj_pkg::OP_NEXT_LIST;
        end else begin
          cmd.op      = smcj_pkg::OP_JOIN_INIT;
          in_adv_next = 1'b0;
          state_next  = ST_SEEK_TOP;
        end
      end
      ST_SRT_KI: begin
        cmd.op     = smcj_pkg::OP_CAP_KI;
        state_next = ST_SRT_SCAN;
      end
      ST_SRT_SCAN: begin
        cmd.op = smcj_pkg::OP_SCAN;
        if (stat.scan_done) state_next = ST_SRT_WR;
      end
      ST_SRT_WR: begin
        cmd.op     = smcj_pkg::OP_WR_ORD;
        state_next = ST_SRT_TOP;
      end
      ST_SEEK_TOP: begin
        if (stat.have) begin
          cmd.op     = smcj_pkg::OP_FETCH_ORD;
          state_next = ST_SEEK_F2;
        end else begin
          cmd.op     = smcj_pkg::OP_SET_RUN;
          state_next = in_adv ? ST_EMIT : ST_PULL_CHK;
        end
      end
      ST_SEEK_F2: begin
        cmd.op     = smcj_pkg::OP_FETCH_VAL;
        state_next = ST_SEEK_F3;
      end
      ST_SEEK_F3: begin
        cmd.op     = smcj_pkg::OP_CAPTURE;
        state_next = ST_SEEK_CMP;
      end
      ST_SEEK_CMP: begin
        cmd.op = smcj_pkg::OP_SEEK_STEP;
        if (stat.keys_eq) state_next = in_adv ? ST_EMIT : ST_PULL_CHK;
        else state_next = ST_SEEK_TOP;
      end
      ST_PULL_CHK: begin
        cmd.op      = smcj_pkg::OP_STAGE;
        in_adv_next = 1'b1;
        state_next  = stat.have ? ST_ADV_F1 : ST_EMIT;
      end
      ST_ADV_F1: begin
        cmd.op     = smcj_pkg::OP_FETCH_ORD;
        cmd.nxt    = 1'b1;
        state_next = ST_ADV_F2;
      end
      ST_ADV_F2: begin
        cmd.op     = smcj_pkg::OP_FETCH_VAL;
        state_next = ST_ADV_F3;
      end
      ST_ADV_F3: begin
        cmd.op     = smcj_pkg::OP_CAPTURE;
        state_next = ST_ADV_DEC;
      end
      ST_ADV_DEC: begin
        cmd.op = smcj_pkg::OP_ADV_STEP;
        priority if (stat.adv_b_ok) state_next = ST_EMIT;
        else if (stat.adv_a_ok)     state_next = ST_RB_F1;
        else                        state_next = ST_SEEK_TOP;
      end
      ST_RB_F1: begin
        cmd.op     = smcj_pkg::OP_FETCH_ORD;
        state_next = ST_RB_F2;
      end
      ST_RB_F2: begin
        cmd.op     = smcj_pkg::OP_FETCH_VAL;
        state_next = ST_RB_F3;
      end
      ST_RB_F3: begin
        cmd.op     = smcj_pkg::OP_CAPTURE;
        state_next = ST_RB_SET;
      end
      ST_RB_SET: begin
        cmd.op     = smcj_pkg::OP_TAKE_B;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = smcj_pkg::OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      in_adv <= 1'b0;
    end else begin
      state  <= state_next;
      in_adv <= in_adv_next;
    end
  end

endmodule

/* rtl/sort_merge_collision_join.sv */
// Collision join of two hash lists of up to 1024 64-bit values each. Loads
// (tuser 0 into list A, 1 into list B) and clears (tuser 3) give no result;
// a load into a full list is dropped and sets the sticky overflow flag. A
// pull (tuser 2) gives one result: the next pair of A and B entries whose
// low key_bits bits match, in ascending key order, A then B ascending in
// load position within a key, with the XOR of both values shifted right by
// key_bits; tuser is 0 once no pair remains and tlast marks the final pair.
// The first pull after a load, clear or key_bits write sorts both lists with
// a rank-counting pass through the value memory, then seeks past entries
// whose keys do not match. Later pulls stage the held pair and fetch the
// next positions and values through the registered memories; list B rewinds
// to the start of its key run when A moves on within a key, and the join
// seeks past unmatched entries when it moves to the next key. Loads are
// taken while a result waits.
module sort_merge_collision_join (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [smcj_pkg::KEY_W-1:0]  cfg_wdata,   // key_bits
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [smcj_pkg::VALUE_BITS-1:0] s_tdata, // value
  input  logic [1:0]                  s_tuser,     // action
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [smcj_pkg::OUT_DATA_W-1:0] m_tdata, // pos_a, pos_b, merged_value, overflow
  output logic                        m_tuser,     // valid_res
  output logic                        m_tlast      // last
);

  smcj_pkg::cmd_t  cmd;
  smcj_pkg::stat_t stat;

  smcj_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .action(s_tuser), .stat(stat), .cmd(cmd)
  );

  smcj_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .action(s_tuser), .value(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule

/* rtl/smcj_checker.sv */
module smcj_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // the final pair is a real pair
  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("last flagged on empty result");

  // an empty result carries nothing but the overflow flag
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[83:0] == 84'd0) && !m_tlast)
    else $error("empty result carries data");

endmodule

bind sort_merge_collision_join smcj_checker u_smcj_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

/* test/tb_sort_merge_collision_join.sv */
`timescale 1ns / 100ps

module tb_sort_merge_collision_join;

  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    bit        pair_found;
    bit        final_pair;
    bit [9:0]  a_pos;
    bit [9:0]  b_pos;
    bit [63:0] merged;
    bit        ovf;
  } pair_res_t;

  // Join predictor and store of expected pairs
  class join_scoreboard;
    bit [63:0]   a_vals[smcj_pkg::LIST_DEPTH];
    bit [63:0]   b_vals[smcj_pkg::LIST_DEPTH];
    int unsigned a_ord[smcj_pkg::LIST_DEPTH];
    int unsigned b_ord[smcj_pkg::LIST_DEPTH];
    int unsigned a_cnt, b_cnt, a_cur, b_cur, b_run;
    bit          joining, ovf_flag;
    int unsigned key_w;
    bit          last_found;
    int          errors;
    pair_res_t   pending_pairs[$];

    function new();
      key_w = smcj_pkg::KEY_BITS_RESET;
    endfunction

    function int unsigned eff_w();
      return (key_w > smcj_pkg::VALUE_BITS) ? smcj_pkg::VALUE_BITS : key_w;
    endfunction

    function bit [63:0] key_of(bit [63:0] v);
      int unsigned kb;
      kb = eff_w();
      if (kb == 0) return 0;
      if (kb >= 64) return v;
      return v & ((64'd1 << kb) - 1);
    endfunction

    function bit [63:0] key_a(int unsigned i);
      return key_of(a_vals[a_ord[i]]);
    endfunction

    function bit [63:0] key_b(int unsigned i);
      return key_of(b_vals[b_ord[i]]);
    endfunction

    // stable insertion sort on the key
    function void sort_a();
      int unsigned i, j, p;
      for (i = 0; i < a_cnt; i++) a_ord[i] = i;
      for (i = 1; i < a_cnt; i++) begin
        p = a_ord[i];
        j = i;
        while (j > 0 && key_of(a_vals[a_ord[j-1]]) > key_of(a_vals[p])) begin
          a_ord[j] = a_ord[j-1];
          j--;
        end
        a_ord[j] = p;
      end
    endfunction

    function void sort_b();
      int unsigned i, j, p;
      for (i = 0; i < b_cnt; i++) b_ord[i] = i;
      for (i = 1; i < b_cnt; i++) begin
        p = b_ord[i];
        j = i;
        while (j > 0 && key_of(b_vals[b_ord[j-1]]) > key_of(b_vals[p])) begin
          b_ord[j] = b_ord[j-1];
          j--;
        end
        b_ord[j] = p;
      end
    endfunction

    function void seek();
      while (a_cur < a_cnt && b_cur < b_cnt) begin
        if (key_a(a_cur) < key_b(b_cur)) a_cur++;
        else if (key_b(b_cur) < key_a(a_cur)) b_cur++;
        else break;
      end
      b_run = b_cur;
    endfunction

    function void set_key(int unsigned k);
      key_w = k;
      joining = 0;
    endfunction

    // note an accepted input transfer
    function void note_input(smcj_pkg::action_t act, bit [63:0] v);
      pair_res_t r;
      bit [63:0] k;
      case (act)
        smcj_pkg::ACT_LOAD_A: begin
          if (a_cnt < smcj_pkg::LIST_DEPTH) begin a_vals[a_cnt] = v; a_cnt++; end
          else ovf_flag = 1;
          joining = 0;
        end
        smcj_pkg::ACT_LOAD_B: begin
          if (b_cnt < smcj_pkg::LIST_DEPTH) begin b_vals[b_cnt] = v; b_cnt++; end
          else ovf_flag = 1;
          joining = 0;
        end
        smcj_pkg::ACT_CLEAR: begin
          a_cnt = 0; b_cnt = 0; a_cur = 0; b_cur = 0; b_run = 0;
          joining = 0; ovf_flag = 0;
        end
        default: begin
          if (!joining) begin
            sort_a();
            sort_b();
            a_cur = 0; b_cur = 0;
            seek();
            joining = 1;
          end
          r = '{default: 0};
          r.ovf = ovf_flag;
          if (a_cur < a_cnt && b_cur < b_cnt) begin
            r.pair_found = 1;
            r.a_pos = a_ord[a_cur];
            r.b_pos = b_ord[b_cur];
            r.merged = (eff_w() >= 64) ? 64'd0 :
                       ((a_vals[a_ord[a_cur]] ^ b_vals[b_ord[b_cur]]) >> eff_w());
            k = key_b(b_cur);
            if (b_cur + 1 < b_cnt && key_b(b_cur + 1) == k) b_cur++;
            else if (a_cur + 1 < a_cnt && key_a(a_cur + 1) == k) begin
              a_cur++;
              b_cur = b_run;
            end else begin
              a_cur++; b_cur++;
              seek();
            end
            r.final_pair = !(a_cur < a_cnt && b_cur < b_cnt);
          end
          last_found = r.pair_found;
          pending_pairs.insert(pending_pairs.size(), r);
        end
      endcase
    endfunction

    // compare one accepted result transfer with the oldest expectation
    function void check_result(bit vr, bit lst, bit [smcj_pkg::OUT_DATA_W-1:0] d);
      pair_res_t e;
      if (pending_pairs.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      e = pending_pairs.pop_front();
      if (vr != e.pair_found) begin
        $error("valid_res exp %0d got %0d", e.pair_found, vr); errors++;
      end
      if (lst != e.final_pair) begin
        $error("last exp %0d got %0d", e.final_pair, lst); errors++;
      end
      if (d[9:0] != e.a_pos) begin
        $error("pos_a exp %0d got %0d", e.a_pos, d[9:0]); errors++;
      end
      if (d[19:10] != e.b_pos) begin
        $error("pos_b exp %0d got %0d", e.b_pos, d[19:10]); errors++;
      end
      if (d[83:20] != e.merged) begin
        $error("merged_value exp %h got %h", e.merged, d[83:20]); errors++;
      end
      if (d[84] != e.ovf) begin
        $error("overflow exp %0d got %0d", e.ovf, d[84]); errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_wen;
  logic [smcj_pkg::KEY_W-1:0]      cfg_wdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [63:0]                     s_tdata;
  logic [1:0]                      s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [smcj_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            m_tlast;

  join_scoreboard sb;
  int unsigned    items_sent;
  int unsigned    burst_left;
  int unsigned    hold_cycles;
  bit [63:0]      key_pool[4];

  sort_merge_collision_join dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("sort_merge_collision_join test failed");
    $finish;
  end

  // receiver stall pattern, with an optional long hold-off
  initial begin
    int unsigned pat;
    m_tready = 0;
    pat = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 0;
        hold_cycles--;
      end else begin
        pat++;
        if (pat[7]) m_tready = 1;
        else m_tready = ($urandom_range(0, 3) != 0);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tlast, m_tdata);
  end

  task automatic send(smcj_pkg::action_t act, bit [63:0] v);
    @(negedge clk);
    s_tvalid = 1;
    s_tuser  = act;
    s_tdata  = v;
    do @(posedge clk); while (!s_tready);
    sb.note_input(act, v);
    items_sent++;
    if (burst_left == 0) begin
      @(negedge clk);
      s_tvalid = 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // wait until every expected pair has arrived and the block is quiet
  task automatic drain();
    @(negedge clk);
    s_tvalid = 0;
    while (sb.pending_pairs.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_key(int unsigned k);
    drain();
    @(negedge clk);
    cfg_wen   = 1;
    cfg_wdata = smcj_pkg::KEY_W'(k);
    @(negedge clk);
    cfg_wen = 0;
    sb.set_key(k);
  endtask

  // random value whose key mostly comes from a small pool, so keys collide
  function automatic bit [63:0] pooled_value();
    bit [63:0] v, m;
    int unsigned kb;
    kb = sb.eff_w();
    v  = {$urandom, $urandom};
    m  = (kb == 0) ? 64'd0 : (kb >= 64) ? '1 : ((64'd1 << kb) - 1);
    if ($urandom_range(0, 7) == 0) return v;
    return (v & ~m) | (key_pool[$urandom_range(0, 3)] & m);
  endfunction

  // pull until the join reports no pair left, plus one more
  task automatic pull_all();
    int unsigned n;
    n = 0;
    do begin
      send(smcj_pkg::ACT_PULL, {$urandom, $urandom});
      n++;
    end while (sb.last_found && n < 300);
    send(smcj_pkg::ACT_PULL, 64'd0);
  endtask

  task automatic join_round(int unsigned na, int unsigned nb);
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    send(smcj_pkg::ACT_CLEAR, {$urandom, $urandom});
    for (int unsigned i = 0; i < na; i++) send(smcj_pkg::ACT_LOAD_A, pooled_value());
    for (int unsigned i = 0; i < nb; i++) send(smcj_pkg::ACT_LOAD_B, pooled_value());
    pull_all();
  endtask

  initial begin
    int unsigned kb_list[5];
    sb = new();
    rst = 1; cfg_wen = 0; cfg_wdata = '0;
    s_tvalid = 0; s_tdata = 0; s_tuser = smcj_pkg::ACT_CLEAR;
    hold_cycles = 0; burst_left = 0; items_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty join, extreme values, equal keys at reset key width
    send(smcj_pkg::ACT_PULL, 64'd0);
    send(smcj_pkg::ACT_LOAD_A, 64'd0);
    send(smcj_pkg::ACT_LOAD_A, '1);
    send(smcj_pkg::ACT_LOAD_A, 64'h1234_0000);
    send(smcj_pkg::ACT_LOAD_B, 64'hFFFF_FFFF_FFFF_0000);
    send(smcj_pkg::ACT_LOAD_B, '1);
    send(smcj_pkg::ACT_LOAD_B, 64'h0000_0000_0001_FFFF);
    pull_all();
    // load during a join restarts it
    send(smcj_pkg::ACT_PULL, 64'd0);
    send(smcj_pkg::ACT_LOAD_B, 64'h5555_0000);
    pull_all();
    // key widths zero, 64 and above 64 (all register bits set)
    kb_list = '{0, 1, 64, 127, 63};
    foreach (kb_list[i]) begin
      write_key(kb_list[i]);
      join_round(3, 3);
    end

    // full list: overflow flag, then cleared
    write_key(4);
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    send(smcj_pkg::ACT_CLEAR, 64'd0);
    for (int unsigned i = 0; i < smcj_pkg::LIST_DEPTH + 2; i++)
      send(smcj_pkg::ACT_LOAD_A, {$urandom, $urandom});
    send(smcj_pkg::ACT_LOAD_B, {$urandom, $urandom});
    send(smcj_pkg::ACT_LOAD_B, {$urandom, $urandom});
    pull_all();
    send(smcj_pkg::ACT_CLEAR, 64'd0);
    send(smcj_pkg::ACT_PULL, 64'd0);

    // receiver holds off for a long stretch while pulls keep coming
    write_key(2);
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    send(smcj_pkg::ACT_CLEAR, 64'd0);
    for (int i = 0; i < 6; i++) send(smcj_pkg::ACT_LOAD_A, pooled_value());
    for (int i = 0; i < 6; i++) send(smcj_pkg::ACT_LOAD_B, pooled_value());
    hold_cycles = 600;
    for (int i = 0; i < 20; i++) send(smcj_pkg::ACT_PULL, 64'd0);
    drain();

    // random rounds over random key widths
    while (items_sent < 1200) begin
      case ($urandom_range(0, 5))
        0: write_key($urandom_range(0, 127));
        1: write_key($urandom_range(1, 8));
        2: drain();
        default: ;
      endcase
      if ($urandom_range(0, 5) == 0) begin
        // noise: random actions, including loads mid-join
        repeat ($urandom_range(5, 20)) begin
          case ($urandom_range(0, 3))
            0: send(smcj_pkg::ACT_LOAD_A, pooled_value());
            1: send(smcj_pkg::ACT_LOAD_B, pooled_value());
            2: send(smcj_pkg::ACT_PULL, {$urandom, $urandom});
            default: if ($urandom_range(0, 3) == 0) send(smcj_pkg::ACT_CLEAR, 64'd0);
          endcase
        end
      end else begin
        join_round($urandom_range(0, 12), $urandom_range(0, 12));
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pairs.size() == 0)
      $display("sort_merge_collision_join test passed");
    else
      $display("sort_merge_collision_join test failed");
    $finish;
  end

endmodule
